// ===== design/dc_pkg.sv =====
// Package for the divisor count core: sizes, result limits and sequencer states.
// Used by dc_divider and divisor_count_core; has no dependencies of its own.
package dc_pkg;

    // Default width of the signed input value
    localparam int VALUE_WIDTH_DEF = 32;

    // Result field: 11 bits, saturating at its top code
    localparam int TOTAL_W     = 11;
    localparam int TOTAL_MAX   = 2047;
    localparam int OUT_TDATA_W = 16;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_MUL,
        ST_TAIL,
        ST_OUT
    } dc_state_t;

endpackage

// ===== design/divisor_count_core.sv =====
// Top level of the divisor count core: input word, trial-division sequencer, output register.
// Uses dc_pkg and the shared divider dc_divider.
//
// Takes one signed VALUE_WIDTH-bit word and returns the number of positive divisors of its
// magnitude (1 for zero and for plus or minus one), saturating at 2047. The magnitude is
// factored by trial division from 2 while the trial divisor does not exceed the quotient.
// Every trial is one pass of a shared bit-serial divider. At the default 32 bits, prime
// magnitudes near 2^31 are the worst case. s_tready is high only between words. The result
// sits in an output register, so the next word may be taken while a result still waits on
// m_tready.
module divisor_count_core
    import dc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]  s_tdata,  // [VALUE_WIDTH-1:0] value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_TDATA_W-1:0]            m_tdata   // [10:0] divisor_total
);

    localparam int W   = VALUE_WIDTH;
    localparam int E_W = $clog2(VALUE_WIDTH + 1);
    localparam int P_W = TOTAL_W + E_W;
    localparam logic [P_W-1:0] SAT_P = P_W'(TOTAL_MAX);

    dc_state_t        state_reg, state_next;
    logic [W-1:0]     mag_reg, mag_next;
    logic [W-1:0]     d_reg, d_next;
    logic [E_W-1:0]   e_reg, e_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic             first_reg, first_next;
    logic             out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] out_data_reg, out_data_next;

    logic [W-1:0]     in_value;
    logic [W-1:0]     in_mag;
    logic             div_start;
    logic             div_done;
    logic [W-1:0]     div_q;
    logic [W-1:0]     div_r;
    logic [P_W-1:0]   prod;
    logic [TOTAL_W:0] dbl;

    // Magnitude of the incoming word, taken as unsigned
    assign in_value = s_tdata[W-1:0];
    assign in_mag   = in_value[W-1] ? (~in_value + 1'b1) : in_value;

    // Saturating count updates
    assign prod = {{E_W{1'b0}}, total_reg} * {{TOTAL_W{1'b0}}, e_reg + 1'b1};
    assign dbl  = {total_reg, 1'b0};

    // Shared divider: mag_reg / d_reg
    dc_divider #(
        .WIDTH (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        total_next     = total_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mag_next   = in_mag;
                    d_next     = W'(2);
                    e_next     = '0;
                    total_next = TOTAL_W'(1);
                    first_next = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (first_reg && (d_reg > div_q))
                    begin
                        state_next = ST_TAIL;
                    end
                    else if (div_r == '0)
                    begin
                        e_next     = e_reg + 1'b1;
                        mag_next   = div_q;
                        first_next = 1'b0;
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                total_next = (prod > SAT_P) ? TOTAL_W'(TOTAL_MAX) : prod[TOTAL_W-1:0];
                e_next     = '0;
                d_next     = d_reg + 1'b1;
                first_next = 1'b1;
                state_next = ST_START;
            end
            ST_TAIL:
            begin
                if (mag_reg > W'(1))
                begin
                    total_next = dbl[TOTAL_W] ? TOTAL_W'(TOTAL_MAX) : dbl[TOTAL_W-1:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        d_reg        <= d_next;
        e_reg        <= e_next;
        total_reg    <= total_next;
        first_reg    <= first_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-TOTAL_W){1'b0}}, out_data_reg};

    // Checks
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_WAIT)
        else $error("divider finished outside the wait state");

    a_trial_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_OUT) |-> d_reg >= W'(2))
        else $error("trial divisor below two");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == ST_START)
        else $error("accepted word did not start a divide");

    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[TOTAL_W-1:0] != '0)
        else $error("divisor total of zero");

endmodule

// ===== design/dc_divider.sv =====
// Shared restoring divider: one quotient bit per cycle.
// Uses dc_pkg; instantiated by divisor_count_core.
module dc_divider
    import dc_pkg::*;
#(
    parameter int WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;

    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   diff;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
